// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sbrp_pkg.sv =====
package sbrp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_WAIT,
        PH_ATTR,
        PH_VALUE,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_TYPE,
        ST_OVERRUN,
        ST_NOADDR
    } t_status;

    localparam logic [15:0] MSG_BIND_RESP   = 16'h0101;
    localparam logic [31:0] COOKIE_RESET    = 32'h2112A442;
    localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
    localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
    localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
    localparam logic [16:0] HDR_BYTES       = 17'd20;
    localparam logic [16:0] START_MAX       = 17'h1FFFF;
    localparam logic        REG_COOKIE      = 1'b0;

endpackage

// ===== rtl/core/sbrp_ifs.sv =====
interface sbrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sbrp_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [2:0]  status;
    logic [31:0] ext_ip;
    logic [15:0] ext_port;
    logic        from_xor;

    modport source (output valid, output found, output status, output ext_ip,
                    output ext_port, output from_xor, input ready);
    modport sink   (input valid, input found, input status, input ext_ip,
                    input ext_port, input from_xor, output ready);
endinterface

// ===== rtl/core/stun_binding_response_parser.sv =====
// The result for a datagram is registered and valid in the cycle after its last byte transfers.
// Throughput: 1 byte per cycle; only a last byte waits, and only while the result
// register still holds an untaken result.
// Reset: i_rst_n synchronous, active low; clears parse state and the result valid,
// and loads cookie with 0x2112A442. Parse state also returns to reset after each last byte.
module stun_binding_response_parser
    import sbrp_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbrp_byte_if.sink     i_in,
    sbrp_result_if.source o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int unsigned OW = $clog2(MAX_BYTES + 1);
    localparam logic [OW-1:0] MAX_OFF = OW'(MAX_BYTES);

    logic [31:0]   r_cookie;
    logic [OW-1:0] r_off,   n_off;
    logic [15:0]   r_mtype, n_mtype;
    logic [15:0]   r_mlen,  n_mlen;
    logic [15:0]   r_atype, n_atype;
    logic [15:0]   r_alen,  n_alen;
    logic [16:0]   r_nas,   n_nas;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_pfam,  n_pfam;
    logic [15:0]   r_pport, n_pport;
    logic [31:0]   r_paddr, n_paddr;
    logic [31:0]   r_kaddr, n_kaddr;
    logic [15:0]   r_kport, n_kport;
    logic          r_kvalid, n_kvalid;
    logic          r_kxor,  n_kxor;

    logic          r_out_valid;
    logic          r_found;
    t_status       r_status, n_status;
    logic [31:0]   r_ip;
    logic [15:0]   r_port;
    logic          r_xor;

    logic          accept, live, step, fin;
    logic [7:0]    d;
    logic [16:0]   off17, rel, vrel, nas_adv;
    logic [17:0]   msg_end, pad_len, span, fit_cur_sum, fit_adv_sum;
    logic [18:0]   adv_sum;
    logic          fit_cur, fit_adv, vdone, alen_zero;

    // ---- config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COOKIE) ? r_cookie : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cookie <= COOKIE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_COOKIE) begin
            r_cookie <= pwdata;
        end
    end

    // ---- handshake
    assign i_in.ready = !r_out_valid || o_out.ready || !i_in.last_byte;
    assign accept     = i_in.valid && i_in.ready;
    assign live       = r_off < MAX_OFF;
    assign step       = accept && live;
    assign fin        = accept && i_in.last_byte;
    assign d          = i_in.data_byte;

    // ---- offsets and fit checks
    assign off17     = 17'(r_off);
    assign rel       = off17 - r_nas;
    assign vrel      = off17 - r_nas - 17'd4;
    assign msg_end   = 18'(HDR_BYTES) + 18'(r_mlen);
    assign pad_len   = (18'(r_alen) + 18'd3) & ~18'd3;
    assign span      = (r_phase == PH_VALUE) ? (18'd4 + pad_len) : 18'd4;
    assign adv_sum   = 19'(r_nas) + 19'(span);
    assign nas_adv   = (adv_sum > 19'(START_MAX)) ? START_MAX : adv_sum[16:0];
    assign fit_cur_sum = 18'(r_nas) + 18'd4;
    assign fit_adv_sum = 18'(nas_adv) + 18'd4;
    assign fit_cur   = fit_cur_sum <= msg_end;
    assign fit_adv   = fit_adv_sum <= msg_end;
    assign vdone     = (18'(vrel) + 18'd1) == 18'(r_alen);
    assign alen_zero = (r_alen[15:8] == 8'd0) && (d == 8'd0);

    // ---- phase next state
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (off17 >= 17'd19) begin
                        n_phase = fit_cur ? PH_WAIT : PH_DONE;
                    end
                end
                PH_WAIT: begin
                    if (off17 == r_nas) begin
                        n_phase = PH_ATTR;
                    end
                end
                PH_ATTR: begin
                    if (rel[1:0] == 2'd3) begin
                        if (alen_zero) begin
                            n_phase = fit_adv ? PH_WAIT : PH_DONE;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    if (vdone) begin
                        n_phase = fit_adv ? PH_WAIT : PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: n_phase = PH_HEADER;
            endcase
        end
        if (fin) begin
            n_phase = PH_HEADER;
        end
    end

    // ---- field capture
    always_comb begin
        n_off    = r_off;
        n_mtype  = r_mtype;
        n_mlen   = r_mlen;
        n_atype  = r_atype;
        n_alen   = r_alen;
        n_nas    = r_nas;
        n_pfam   = r_pfam;
        n_pport  = r_pport;
        n_paddr  = r_paddr;
        n_kaddr  = r_kaddr;
        n_kport  = r_kport;
        n_kvalid = r_kvalid;
        n_kxor   = r_kxor;
        if (step) begin
            n_off = r_off + OW'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (off17 == 17'd0) n_mtype[15:8] = d;
                    if (off17 == 17'd1) n_mtype[7:0]  = d;
                    if (off17 == 17'd2) n_mlen[15:8]  = d;
                    if (off17 == 17'd3) n_mlen[7:0]   = d;
                end
                PH_WAIT: begin
                    if (off17 == r_nas) begin
                        n_pfam        = 8'd0;
                        n_pport       = 16'd0;
                        n_paddr       = 32'd0;
                        n_atype[15:8] = d;
                    end
                end
                PH_ATTR: begin
                    case (rel[1:0])
                        2'd0: n_atype[15:8] = d;
                        2'd1: n_atype[7:0]  = d;
                        2'd2: n_alen[15:8]  = d;
                        default: begin
                            n_alen[7:0] = d;
                            if (alen_zero) n_nas = nas_adv;
                        end
                    endcase
                end
                PH_VALUE: begin
                    if (vrel == 17'd1) n_pfam = d;
                    if (vrel == 17'd2) n_pport[15:8] = d;
                    if (vrel == 17'd3) n_pport[7:0]  = d;
                    if (vrel >= 17'd4 && vrel <= 17'd7) n_paddr = {r_paddr[23:0], d};
                    if (vdone) begin
                        n_nas = nas_adv;
                        if (r_atype == ATTR_XOR_MAPPED && r_alen >= 16'd8) begin
                            if (n_pfam == FAMILY_IPV4) begin
                                n_kaddr  = n_paddr ^ r_cookie;
                                n_kport  = n_pport ^ r_cookie[31:16];
                                n_kvalid = 1'b1;
                                n_kxor   = 1'b1;
                            end
                        end else if (r_atype == ATTR_MAPPED && r_alen >= 16'd8 && !r_kvalid) begin
                            if (n_pfam == FAMILY_IPV4) begin
                                n_kaddr  = n_paddr;
                                n_kport  = n_pport;
                                n_kvalid = 1'b1;
                                n_kxor   = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- result
    always_comb begin
        if (17'(n_off) < HDR_BYTES) begin
            n_status = ST_SHORT;
        end else if (n_mtype != MSG_BIND_RESP) begin
            n_status = ST_TYPE;
        end else if (18'(n_off) < 18'(HDR_BYTES) + 18'(n_mlen)) begin
            n_status = ST_OVERRUN;
        end else if (!n_kvalid) begin
            n_status = ST_NOADDR;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_off    <= '0;
            r_mtype  <= '0;
            r_mlen   <= '0;
            r_atype  <= '0;
            r_alen   <= '0;
            r_nas    <= HDR_BYTES;
            r_pfam   <= '0;
            r_pport  <= '0;
            r_paddr  <= '0;
            r_kaddr  <= '0;
            r_kport  <= '0;
            r_kvalid <= 1'b0;
            r_kxor   <= 1'b0;
        end else begin
            r_off    <= n_off;
            r_mtype  <= n_mtype;
            r_mlen   <= n_mlen;
            r_atype  <= n_atype;
            r_alen   <= n_alen;
            r_nas    <= n_nas;
            r_pfam   <= n_pfam;
            r_pport  <= n_pport;
            r_paddr  <= n_paddr;
            r_kaddr  <= n_kaddr;
            r_kport  <= n_kport;
            r_kvalid <= n_kvalid;
            r_kxor   <= n_kxor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status <= n_status;
            r_found  <= (n_status == ST_OK);
            r_ip     <= (n_status == ST_OK) ? n_kaddr : 32'd0;
            r_port   <= (n_status == ST_OK) ? n_kport : 16'd0;
            r_xor    <= (n_status == ST_OK) ? n_kxor  : 1'b0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_found;
    assign o_out.status   = r_status;
    assign o_out.ext_ip   = r_ip;
    assign o_out.ext_port = r_port;
    assign o_out.from_xor = r_xor;

endmodule

// ===== rtl/core/sbrp_checker.sv =====
`include "assert_macros.svh"

module sbrp_checker
    import sbrp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [2:0]  i_status,
    input logic [31:0] i_ip,
    input logic [15:0] i_port,
    input logic        i_xor
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                 i_out_valid && $stable(i_status) && $stable(i_ip) && $stable(i_port))
    `ASSERT_NOW(a_found_ok, i_clk, i_rst_n, i_out_valid, i_found == (i_status == ST_OK))
    `ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, i_out_valid && !i_found,
                i_ip == 32'd0 && i_port == 16'd0 && !i_xor)
    `ASSERT_NOW(a_from_last, i_clk, i_rst_n, $rose(i_out_valid),
                $past(i_in_valid && i_in_ready && i_in_last))
    `ASSERT_NEXT(a_reload, i_clk, i_rst_n, i_out_valid && i_out_ready,
                 !i_out_valid || $past(i_in_valid && i_in_ready && i_in_last))

endmodule

bind stun_binding_response_parser sbrp_checker u_sbrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_found     (o_out.found),
    .i_status    (o_out.status),
    .i_ip        (o_out.ext_ip),
    .i_port      (o_out.ext_port),
    .i_xor       (o_out.from_xor)
);
